FILE: hdl/clmi_pkg.sv
// Shared codes and types for the color map interpolator.
package clmi_pkg;

    // Position mapping modes
    localparam logic [1:0] MODE_CLIP      = 2'd0;
    localparam logic [1:0] MODE_REPEAT    = 2'd1;
    localparam logic [1:0] MODE_MIRROR    = 2'd2;
    localparam logic [1:0] MODE_DIVERGING = 2'd3;

    // Configuration register indexes
    localparam logic REG_MAPPING_MODE = 1'b0;
    localparam logic REG_STOP_COUNT   = 1'b1;

    // Op codes of an input transaction
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // Quotient bits of the per-channel divider
    localparam int QUO_W = 8;

    // Control from the sequencer to the channel interpolators
    typedef struct packed {
        logic       load;
        logic       mul;
        logic       step;
        logic [2:0] k;
    } lerp_ctl_t;

endpackage

FILE: hdl/clmi_cell.sv
// One color stop cell: holds a stop and advances the search token by one slot.
module clmi_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5,
    parameter int PW    = 17,
    parameter int V2W   = 22
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [PW-1:0]         wr_pos,
    input  logic [31:0]           wr_color,
    input  logic [CNT_W-1:0]      n,
    input  logic [PW-1:0]         prev_pos,
    input  logic [31:0]           prev_color,
    output logic [PW-1:0]         pos,
    output logic [31:0]           color,
    input  logic                  tin_valid,
    input  logic signed [V2W-1:0] tin_v2,
    input  logic                  tin_found,
    input  logic [PW-1:0]         tin_lp,
    input  logic [31:0]           tin_lc,
    input  logic [PW-1:0]         tin_rp,
    input  logic [31:0]           tin_rc,
    input  logic [PW-1:0]         tin_lastp,
    input  logic [31:0]           tin_lastc,
    output logic                  tout_valid,
    output logic signed [V2W-1:0] tout_v2,
    output logic                  tout_found,
    output logic [PW-1:0]         tout_lp,
    output logic [31:0]           tout_lc,
    output logic [PW-1:0]         tout_rp,
    output logic [31:0]           tout_rc,
    output logic [PW-1:0]         tout_lastp,
    output logic [31:0]           tout_lastc
);
    import clmi_pkg::*;

    logic [PW-1:0]         pos_reg;
    logic [31:0]           color_reg;
    logic                  valid_reg;
    logic signed [V2W-1:0] v2_reg;
    logic                  found_reg;
    logic [PW-1:0]         lp_reg;
    logic [31:0]           lc_reg;
    logic [PW-1:0]         rp_reg;
    logic [31:0]           rc_reg;
    logic [PW-1:0]         lastp_reg;
    logic [31:0]           lastc_reg;
    logic signed [V2W-1:0] pos2;
    logic                  active;
    logic                  hit;
    logic                  is_last;

    // Hold the stop written by a load
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == IDX_W'(IDX)))
        begin
            pos_reg   <= wr_pos;
            color_reg <= wr_color;
        end
    end

    assign pos   = pos_reg;
    assign color = color_reg;

    // Compare the token against this stop
    assign pos2    = signed'({{(V2W-PW-1){1'b0}}, pos_reg, 1'b0});
    assign active  = tin_valid && (CNT_W'(IDX) < n);
    assign hit     = active && (IDX != 0) && !tin_found && (pos2 > tin_v2);
    assign is_last = active && (CNT_W'(IDX + 1) == n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tin_valid;
        end
    end

    // Advance the token, capturing the bracket and the last stop
    always_ff @(posedge clk)
    begin
        v2_reg    <= tin_v2;
        found_reg <= tin_found || hit;
        lp_reg    <= hit ? prev_pos : tin_lp;
        lc_reg    <= hit ? prev_color : tin_lc;
        rp_reg    <= hit ? pos_reg : tin_rp;
        rc_reg    <= hit ? color_reg : tin_rc;
        lastp_reg <= is_last ? pos_reg : tin_lastp;
        lastc_reg <= is_last ? color_reg : tin_lastc;
    end

    assign tout_valid = valid_reg;
    assign tout_v2    = v2_reg;
    assign tout_found = found_reg;
    assign tout_lp    = lp_reg;
    assign tout_lc    = lc_reg;
    assign tout_rp    = rp_reg;
    assign tout_rc    = rc_reg;
    assign tout_lastp = lastp_reg;
    assign tout_lastc = lastc_reg;

endmodule

FILE: hdl/clmi_lerp.sv
// One color channel interpolator: multiply, then restoring floor division.
module clmi_lerp #(
    parameter int TW = 18
) (
    input  logic                clk,
    input  clmi_pkg::lerp_ctl_t ctl,
    input  logic [7:0]          a_in,
    input  logic [7:0]          b_in,
    input  logic [TW-1:0]       t_in,
    input  logic [TW-1:0]       den_in,
    output logic [7:0]          result
);
    import clmi_pkg::*;

    localparam int RW = TW + QUO_W;

    logic [7:0]       a_reg;
    logic [7:0]       d_reg;
    logic             neg_reg;
    logic [TW-1:0]    t_reg;
    logic [TW-1:0]    den_reg;
    logic [RW-1:0]    rem_reg;
    logic [QUO_W-1:0] q_reg;
    logic [RW-1:0]    shifted;
    logic             fits;
    logic             neg_next;

    assign neg_next = b_in < a_in;
    assign shifted  = RW'(den_reg) << ctl.k;
    assign fits     = rem_reg >= shifted;

    // Operand load, product, then one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg   <= a_in;
            neg_reg <= neg_next;
            d_reg   <= neg_next ? (a_in - b_in) : (b_in - a_in);
            t_reg   <= t_in;
            den_reg <= den_in;
        end
        if (ctl.mul)
        begin
            rem_reg <= RW'(d_reg) * RW'(t_reg);
            q_reg   <= '0;
        end
        else if (ctl.step && fits)
        begin
            rem_reg        <= rem_reg - shifted;
            q_reg[ctl.k]   <= 1'b1;
        end
    end

    // Floor toward minus infinity on a falling channel
    assign result = neg_reg ? (a_reg - q_reg - {7'b0, (rem_reg != '0)})
                            : (a_reg + q_reg);

endmodule

FILE: hdl/colormap_interpolator.sv
// Top level of the piecewise linear color map interpolator.
//
// A load transaction writes one color stop. A map transaction runs alone: the
// sample passes once down the row of MAX_STOPS stop cells, one cell a cycle,
// then the four channels are interpolated by a multiply and an 8-step divider.
// A sample that returns a stop color as is skips the multiply and the divider
// and goes from the scan straight to the output state; the next transaction is
// taken once the result sits in the output register.
module colormap_interpolator #(
    parameter int MAX_STOPS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [$clog2(MAX_STOPS)-1:0]  stop_index,
    input  logic [FRAC_BITS:0]            stop_position,
    input  logic [7:0]                    stop_red,
    input  logic [7:0]                    stop_green,
    input  logic [7:0]                    stop_blue,
    input  logic [7:0]                    stop_alpha,
    input  logic signed [FRAC_BITS+3:0]   sample_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_red,
    output logic [7:0]                    out_green,
    output logic [7:0]                    out_blue,
    output logic [7:0]                    out_alpha,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [$clog2(MAX_STOPS+1)-1:0] cfg_data
);
    import clmi_pkg::*;

    localparam int IDX_W = $clog2(MAX_STOPS);
    localparam int CNT_W = $clog2(MAX_STOPS + 1);
    localparam int SW    = FRAC_BITS + 4;
    localparam int PW    = FRAC_BITS + 1;
    localparam int P2W   = FRAC_BITS + 2;
    localparam int V2W   = FRAC_BITS + 6;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [2:0]       k_reg;
    logic [1:0]       mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] n;
    logic             out_valid_reg;
    logic [31:0]      out_color_reg;
    logic             direct_reg;
    logic [31:0]      direct_color_reg;

    logic                  in_acc;
    logic                  map_acc;
    logic                  load_acc;
    logic signed [V2W-1:0] s_ext;
    logic signed [V2W-1:0] s_abs;
    logic signed [V2W-1:0] v2_in;

    // Token chain between cells
    logic                  tv    [0:MAX_STOPS];
    logic signed [V2W-1:0] tv2   [0:MAX_STOPS];
    logic                  tfnd  [0:MAX_STOPS];
    logic [PW-1:0]         tlp   [0:MAX_STOPS];
    logic [31:0]           tlc   [0:MAX_STOPS];
    logic [PW-1:0]         trp   [0:MAX_STOPS];
    logic [31:0]           trc   [0:MAX_STOPS];
    logic [PW-1:0]         tlastp[0:MAX_STOPS];
    logic [31:0]           tlastc[0:MAX_STOPS];
    logic [PW-1:0]         cpos  [0:MAX_STOPS-1];
    logic [31:0]           ccolor[0:MAX_STOPS-1];
    logic [MAX_STOPS-1:0]  tv_vec;

    logic                  scan_done;
    logic signed [V2W-1:0] first2;
    logic signed [V2W-1:0] last2;
    logic signed [V2W-1:0] lp2;
    logic signed [V2W-1:0] rp2;
    logic                  direct_next;
    logic [31:0]           direct_color_next;
    logic [P2W-1:0]        t_val;
    logic [P2W-1:0]        den_val;
    lerp_ctl_t             lctl;
    logic [7:0]            lres [0:3];
    logic                  out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign map_acc   = in_acc && (op == OP_MAP);
    assign load_acc  = in_acc && (op == OP_LOAD);

    // Clamp the stop count to one through MAX_STOPS
    assign n = (count_reg == '0) ? CNT_W'(1) :
               (count_reg > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : count_reg;

    // Remap the sample in units of half an LSB
    assign s_ext = {{(V2W-SW){sample_value[SW-1]}}, sample_value};
    assign s_abs = s_ext[V2W-1] ? -s_ext : s_ext;

    always_comb
    begin
        unique case (mode_reg)
            MODE_CLIP:      v2_in = {s_ext[V2W-2:0], 1'b0};
            MODE_REPEAT:    v2_in = {{(V2W-FRAC_BITS-1){1'b0}},
                                     sample_value[FRAC_BITS-1:0], 1'b0};
            MODE_MIRROR:    v2_in = {s_abs[V2W-2:0], 1'b0};
            MODE_DIVERGING: v2_in = s_ext + (V2W'(1) << FRAC_BITS);
            default:        v2_in = s_ext;
        endcase
    end

    // Inject a map token at the head of the row
    assign tv[0]     = map_acc;
    assign tv2[0]    = v2_in;
    assign tfnd[0]   = 1'b0;
    assign tlp[0]    = '0;
    assign tlc[0]    = '0;
    assign trp[0]    = '0;
    assign trc[0]    = '0;
    assign tlastp[0] = '0;
    assign tlastc[0] = '0;

    generate
        for (genvar g = 0; g < MAX_STOPS; g++)
        begin : g_cell
            logic [PW-1:0] pp;
            logic [31:0]   pc;
            if (g == 0)
            begin : g_head
                assign pp = '0;
                assign pc = '0;
            end
            else
            begin : g_body
                assign pp = cpos[g-1];
                assign pc = ccolor[g-1];
            end

            clmi_cell #(
                .IDX  (g),
                .IDX_W(IDX_W),
                .CNT_W(CNT_W),
                .PW   (PW),
                .V2W  (V2W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (load_acc),
                .wr_idx    (stop_index),
                .wr_pos    (stop_position),
                .wr_color  ({stop_alpha, stop_blue, stop_green, stop_red}),
                .n         (n),
                .prev_pos  (pp),
                .prev_color(pc),
                .pos       (cpos[g]),
                .color     (ccolor[g]),
                .tin_valid (tv[g]),
                .tin_v2    (tv2[g]),
                .tin_found (tfnd[g]),
                .tin_lp    (tlp[g]),
                .tin_lc    (tlc[g]),
                .tin_rp    (trp[g]),
                .tin_rc    (trc[g]),
                .tin_lastp (tlastp[g]),
                .tin_lastc (tlastc[g]),
                .tout_valid(tv[g+1]),
                .tout_v2   (tv2[g+1]),
                .tout_found(tfnd[g+1]),
                .tout_lp   (tlp[g+1]),
                .tout_lc   (tlc[g+1]),
                .tout_rp   (trp[g+1]),
                .tout_rc   (trc[g+1]),
                .tout_lastp(tlastp[g+1]),
                .tout_lastc(tlastc[g+1])
            );

            assign tv_vec[g] = tv[g+1];
        end
    endgenerate

    // Resolve the bracket when the token leaves the row
    assign scan_done = (state_reg == ST_SCAN) && tv[MAX_STOPS];
    assign first2 = signed'({{(V2W-PW-1){1'b0}}, cpos[0], 1'b0});
    assign last2  = signed'({{(V2W-PW-1){1'b0}}, tlastp[MAX_STOPS], 1'b0});
    assign lp2    = signed'({{(V2W-PW-1){1'b0}}, tlp[MAX_STOPS], 1'b0});
    assign rp2    = signed'({{(V2W-PW-1){1'b0}}, trp[MAX_STOPS], 1'b0});
    assign t_val   = P2W'(tv2[MAX_STOPS] - lp2);
    assign den_val = P2W'(rp2 - lp2);

    always_comb
    begin
        direct_next       = 1'b1;
        direct_color_next = trc[MAX_STOPS];
        if ((n == CNT_W'(1)) || (tv2[MAX_STOPS] <= first2))
        begin
            direct_color_next = ccolor[0];
        end
        else if (tv2[MAX_STOPS] >= last2)
        begin
            direct_color_next = tlastc[MAX_STOPS];
        end
        else if (trp[MAX_STOPS] > tlp[MAX_STOPS])
        begin
            direct_next = 1'b0;
        end
    end

    // Drive the channel interpolators
    always_comb
    begin
        lctl.load = scan_done && !direct_next;
        lctl.mul  = (state_reg == ST_MUL);
        lctl.step = (state_reg == ST_DIV);
        lctl.k    = k_reg;
    end

    generate
        for (genvar c = 0; c < 4; c++)
        begin : g_chan
            clmi_lerp #(
                .TW(P2W)
            ) u_lerp (
                .clk   (clk),
                .ctl   (lctl),
                .a_in  (tlc[MAX_STOPS][8*c +: 8]),
                .b_in  (trc[MAX_STOPS][8*c +: 8]),
                .t_in  (t_val),
                .den_in(den_val),
                .result(lres[c])
            );
        end
    endgenerate

    // Sequence one map transaction
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (map_acc) state_next = ST_SCAN;
            ST_SCAN: if (tv[MAX_STOPS]) state_next = direct_next ? ST_OUT : ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (k_reg == 3'd0) state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= 3'd0;
            mode_reg      <= MODE_CLIP;
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL)
            begin
                k_reg <= 3'd7;
            end
            else if (state_reg == ST_DIV)
            begin
                k_reg <= k_reg - 3'd1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MAPPING_MODE: mode_reg  <= cfg_data[1:0];
                    REG_STOP_COUNT:   count_reg <= cfg_data;
                    default:          mode_reg  <= mode_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the resolved direct color and the output transaction
    always_ff @(posedge clk)
    begin
        if (scan_done)
        begin
            direct_reg       <= direct_next;
            direct_color_reg <= direct_color_next;
        end
        if (out_load)
        begin
            out_color_reg <= direct_reg ? direct_color_reg
                                        : {lres[3], lres[2], lres[1], lres[0]};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_color_reg[7:0];
    assign out_green = out_color_reg[15:8];
    assign out_blue  = out_color_reg[23:16];
    assign out_alpha = out_color_reg[31:24];

    // At most one token travels the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tv_vec))
        else $error("more than one map token in the cell row");

    // A token only travels while scanning
    a_token_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (tv_vec != '0) |-> (state_reg == ST_SCAN))
        else $error("token in the row outside the scan state");

    // A map transaction starts a scan
    a_map_scan: assert property (@(posedge clk) disable iff (!rst_n)
        map_acc |=> (state_reg == ST_SCAN))
        else $error("map transaction did not start a scan");

    // The divider ends after its last quotient bit
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && k_reg == 3'd0) |=> (state_reg == ST_OUT))
        else $error("divider did not finish after the last bit");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the piecewise linear color map interpolator.
`timescale 1ns / 1ps

module tb_top;
    import clmi_pkg::*;

    localparam int NSTOPS    = 16;
    localparam int WATCHDOG  = 5000;
    localparam int SETTLE    = 40;
    localparam int LONG_HOLD = 300;

    // Kinds of rows in the directed table
    localparam int ROW_ITEM = 0;
    localparam int ROW_CFG  = 1;

    typedef struct {
        int               kind;
        logic             op;
        logic [3:0]       idx;
        logic [16:0]      pos;
        logic [31:0]      color;
        logic signed [19:0] smp;
        bit               has_exp;
        logic [31:0]      exp_color;
        logic             reg_sel;
        logic [4:0]       reg_val;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [3:0]  stop_index;
    logic [16:0] stop_position;
    logic [7:0]  stop_red;
    logic [7:0]  stop_green;
    logic [7:0]  stop_blue;
    logic [7:0]  stop_alpha;
    logic signed [19:0] sample_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [4:0]  cfg_data;

    // Shadow of the block's registers and stop table
    logic [1:0]  cur_mode;
    logic [4:0]  cur_count;
    logic [16:0] shadow_pos [NSTOPS];
    logic [31:0] shadow_col [NSTOPS];

    logic [31:0] expected_colors [$];
    row_t        directed_rows [$];
    int          errors;
    int          idle_cycles;
    bit          hold_req;
    bit          calm;

    colormap_interpolator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .stop_index    (stop_index),
        .stop_position (stop_position),
        .stop_red      (stop_red),
        .stop_green    (stop_green),
        .stop_blue     (stop_blue),
        .stop_alpha    (stop_alpha),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .out_alpha     (out_alpha),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Remap the sample by mode, bracket it among the stops, interpolate
    function automatic logic [31:0] predict_color(logic signed [19:0] smp);
        longint s, v2, lp, rp, a, b, r;
        int     n, right, left;
        logic [31:0] res;
        s = smp;
        case (cur_mode)
            MODE_CLIP:   v2 = 2 * s;
            MODE_REPEAT: v2 = 2 * (s & 64'hFFFF);
            MODE_MIRROR: v2 = 2 * ((s < 0) ? -s : s);
            default:     v2 = s + 65536;
        endcase
        n = cur_count;
        if (n == 0)
            n = 1;
        if (n > NSTOPS)
            n = NSTOPS;
        if (n == 1 || v2 <= 2 * longint'(shadow_pos[0]))
            return shadow_col[0];
        if (v2 >= 2 * longint'(shadow_pos[n-1]))
            return shadow_col[n-1];
        right = n - 1;
        for (int i = n - 1; i >= 1; i--)
            if (2 * longint'(shadow_pos[i]) > v2)
                right = i;
        left = right - 1;
        lp = 2 * longint'(shadow_pos[left]);
        rp = 2 * longint'(shadow_pos[right]);
        if (rp <= lp)
            return shadow_col[right];
        res = '0;
        for (int c = 0; c < 4; c++)
        begin
            a = shadow_col[left][8*c +: 8];
            b = shadow_col[right][8*c +: 8];
            r = a + floor_quot((b - a) * (v2 - lp), rp - lp);
            if (r < 0)
                r = 0;
            if (r > 255)
                r = 255;
            res[8*c +: 8] = r[7:0];
        end
        return res;
    endfunction

    // Offer one input transaction and update the shadow state on accept
    task automatic send_item(logic o, logic [3:0] idx, logic [16:0] pos,
                             logic [31:0] col, logic signed [19:0] smp,
                             bit has_exp, logic [31:0] exp_color);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op            = o;
        stop_index    = idx;
        stop_position = pos;
        {stop_alpha, stop_blue, stop_green, stop_red} = col;
        sample_value  = smp;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (o == OP_LOAD)
        begin
            shadow_pos[idx] = pos;
            shadow_col[idx] = col;
        end
        else
            expected_colors = {expected_colors,
                               (has_exp ? exp_color : predict_color(smp))};
        @(negedge clk);
    endtask

    // Drain, let the block settle, then write one register
    task automatic write_reg(logic sel, logic [4:0] val);
        in_valid = 1'b0;
        while (expected_colors.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_index = sel;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (sel == REG_MAPPING_MODE)
            cur_mode = val[1:0];
        else
            cur_count = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic row_t ld(int idx, int pos, logic [31:0] col);
        row_t t;
        t = '{kind: ROW_ITEM, op: OP_LOAD, idx: 4'(idx), pos: 17'(pos), color: col,
              smp: '0, has_exp: 1'b0, exp_color: '0, reg_sel: 1'b0, reg_val: '0};
        return t;
    endfunction

    function automatic row_t mp(int smp, bit has_exp, logic [31:0] exp_color);
        row_t t;
        t = '{kind: ROW_ITEM, op: OP_MAP, idx: '0, pos: '0, color: '0,
              smp: 20'(smp), has_exp: has_exp, exp_color: exp_color,
              reg_sel: 1'b0, reg_val: '0};
        return t;
    endfunction

    function automatic row_t cf(logic sel, int val);
        row_t t;
        t = '{kind: ROW_CFG, op: OP_LOAD, idx: '0, pos: '0, color: '0,
              smp: '0, has_exp: 1'b0, exp_color: '0, reg_sel: sel, reg_val: 5'(val)};
        return t;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(row_t r);
        directed_rows = {directed_rows, r};
    endfunction

    // Result receiver with random stalls and one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready = 1'b0;
                repeat (gap_len()) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        logic [31:0] act;
        logic [31:0] exp_c;
        if (rst_n && out_valid && out_ready)
        begin
            act = {out_alpha, out_blue, out_green, out_red};
            if (expected_colors.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, act);
                errors++;
            end
            else
            begin
                exp_c = expected_colors.pop_front();
                for (int c = 0; c < 4; c++)
                    if (act[8*c +: 8] !== exp_c[8*c +: 8])
                    begin
                        $display("%0t: channel %0d expected %h actual %h",
                                 $time, c, exp_c[8*c +: 8], act[8*c +: 8]);
                        errors++;
                    end
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int          pos_q [$];
        int          nmix;
        int          smp;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] half;

        errors        = 0;
        idle_cycles   = 0;
        hold_req      = 1'b0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_LOAD;
        stop_index    = '0;
        stop_position = '0;
        {stop_alpha, stop_blue, stop_green, stop_red} = '0;
        sample_value  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_MAPPING_MODE;
        cfg_data      = '0;
        cur_mode      = MODE_CLIP;
        cur_count     = 5'd1;
        for (int i = 0; i < NSTOPS; i++)
        begin
            shadow_pos[i] = '0;
            shadow_col[i] = '0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: slot 0 opaque blue at 0.0, slot 1 transparent yellow at 1.0
        c0   = 32'hFFFF0000;
        c1   = 32'h0000FFFF;
        half = 32'h7F7F7F7F;
        add_row(ld(0, 0, c0));
        add_row(ld(1, 65536, c1));
        add_row(mp(-524288, 1, c0));
        add_row(mp(524287, 1, c0));
        add_row(cf(REG_STOP_COUNT, 2));
        add_row(mp(0, 1, c0));
        add_row(mp(65536, 1, c1));
        add_row(mp(32768, 1, half));
        add_row(mp(-524288, 1, c0));
        add_row(mp(524287, 1, c1));
        add_row(mp(16384, 0, '0));
        add_row(cf(REG_MAPPING_MODE, MODE_MIRROR));
        add_row(mp(-524288, 1, c1));
        add_row(mp(-32768, 1, half));
        add_row(cf(REG_MAPPING_MODE, MODE_REPEAT));
        add_row(mp(-1, 0, '0));
        add_row(mp(163840, 1, half));
        add_row(cf(REG_MAPPING_MODE, MODE_DIVERGING));
        add_row(mp(-65536, 1, c0));
        add_row(mp(65536, 1, c1));
        add_row(mp(0, 1, half));
        add_row(mp(-524288, 1, c0));
        add_row(mp(524287, 1, c1));
        // Zero stop count acts as a single stop
        add_row(cf(REG_STOP_COUNT, 0));
        add_row(mp(65536, 1, c0));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
            else
                send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].pos,
                          directed_rows[i].color, directed_rows[i].smp,
                          directed_rows[i].has_exp, directed_rows[i].exp_color);
        end

        // Random phases: new settings, a full table load, then mixed traffic
        for (int ph = 0; ph < 9; ph++)
        begin
            write_reg(REG_MAPPING_MODE, 5'($urandom_range(0, 3)));
            case (ph)
                0: write_reg(REG_STOP_COUNT, 5'd16);
                1: write_reg(REG_STOP_COUNT, 5'd31);
                2: write_reg(REG_STOP_COUNT, 5'd17);
                3: write_reg(REG_STOP_COUNT, 5'd1);
                4: write_reg(REG_STOP_COUNT, 5'd2);
                default: write_reg(REG_STOP_COUNT, 5'($urandom_range(0, 31)));
            endcase
            calm = (ph == 5);

            // Ascending positions; some phases unsorted or with repeats
            pos_q.delete();
            for (int i = 0; i < NSTOPS; i++)
                pos_q = {pos_q, int'($urandom_range(0, 65536))};
            if (ph % 3 != 2)
                pos_q.sort();
            if (ph == 4)
            begin
                pos_q[0] = 0;
                pos_q[NSTOPS-1] = 65536;
            end
            if (ph == 6)
                for (int i = 1; i < NSTOPS; i += 3)
                    pos_q[i] = pos_q[i-1];
            for (int i = 0; i < NSTOPS; i++)
                send_item(OP_LOAD, 4'(i), 17'(pos_q[i]), $urandom(), '0, 1'b0, '0);

            nmix = $urandom_range(80, 100);
            for (int k = 0; k < nmix; k++)
            begin
                if (ph == 3 && k == 10)
                begin
                    calm = 1'b1;
                    hold_req = 1'b1;
                end
                if (ph == 3 && k == 40)
                    calm = 1'b0;
                case ($urandom_range(0, 9))
                    0: smp = $urandom_range(0, 20'hFFFFF) - 524288;
                    1: smp = $urandom_range(0, 1) ? 524287 : -524288;
                    default: smp = $urandom_range(0, 200000) - 70000;
                endcase
                if ($urandom_range(0, 9) == 0)
                    send_item(OP_LOAD, 4'($urandom_range(0, 15)),
                              17'($urandom_range(0, 65536)), $urandom(), 20'(smp),
                              1'b0, '0);
                else
                    send_item(OP_MAP, 4'($urandom()), 17'($urandom()), $urandom(),
                              20'(smp), 1'b0, '0);
            end
        end

        // Drain and let the pipeline settle
        in_valid = 1'b0;
        while (expected_colors.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
